FILE: hdl/lmts_pkg.sv
// Shared types, command codes and font table for the LED matrix text scroller.
// No dependencies; imported by the sequencer, the shift unit and the top level.
package lmts_pkg;

  localparam int unsigned ROWS = 8;
  localparam int unsigned ROW_W = 8;
  localparam int unsigned ROW_IDX_W = 3;
  localparam int unsigned FRAME_IDX_W = 3;
  localparam int unsigned GLYPH_IDX_W = 5;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Frame count minus one for each run.
  localparam logic [FRAME_IDX_W-1:0] START_LAST = 3'd7;
  localparam logic [FRAME_IDX_W-1:0] GLYPH_LAST = 3'd6;
  localparam logic [FRAME_IDX_W-1:0] SPACE_LAST = 3'd2;
  localparam logic [FRAME_IDX_W-1:0] FINISH_LAST = 3'd6;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_CHAR   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic                   clear;
    logic                   step;
    logic [ROW_IDX_W-1:0]   row_idx;
    logic [FRAME_IDX_W-1:0] frame_idx;
    logic                   shift_en;
    logic                   use_glyph;
    logic [GLYPH_IDX_W-1:0] glyph_idx;
    logic                   frame_end;
    logic                   last;
  } run_ctrl_t;

  function automatic logic [7:0] font_row(input logic [GLYPH_IDX_W-1:0] g,
                                          input logic [ROW_IDX_W-1:0] r);
    logic [63:0] glyph;
    case (g)
      5'd0:  glyph = 64'h003c42427e424242;
      5'd1:  glyph = 64'h007c42427e42427c;
      5'd2:  glyph = 64'h003c42404040423c;
      5'd3:  glyph = 64'h007c42424242427c;
      5'd4:  glyph = 64'h007e40407c40407e;
      5'd5:  glyph = 64'h007e40407c404040;
      5'd6:  glyph = 64'h003c42404742423c;
      5'd7:  glyph = 64'h004242427e424242;
      5'd8:  glyph = 64'h007e18181818187e;
      5'd9:  glyph = 64'h007e181818185830;
      5'd10: glyph = 64'h0044444870484442;
      5'd11: glyph = 64'h004040404040407e;
      5'd12: glyph = 64'h0042665a5a424242;
      5'd13: glyph = 64'h004262524a464242;
      5'd14: glyph = 64'h003c42424242423c;
      5'd15: glyph = 64'h007c42427c404040;
      5'd16: glyph = 64'h003c4242424a463b;
      5'd17: glyph = 64'h007c42427c484442;
      5'd18: glyph = 64'h003c42403c02423c;
      5'd19: glyph = 64'h007e181818181818;
      5'd20: glyph = 64'h004242424242423c;
      5'd21: glyph = 64'h0042424242422418;
      5'd22: glyph = 64'h00425a5a5a5a5a3c;
      5'd23: glyph = 64'h0042241818182442;
      5'd24: glyph = 64'h0062361c18306040;
      5'd25: glyph = 64'h007e060c1830607e;
      default: glyph = 64'h0;
    endcase
    font_row = glyph[(7 - r) * 8 +: 8];
  endfunction

endpackage

FILE: hdl/lmts_shift_unit.sv
// Shared row shifter: when enabled, shifts one frame row left and feeds in a font or zero bit.
// Depends on lmts_pkg for widths and the font table.
module lmts_shift_unit
  import lmts_pkg::*;
(
  input  logic [ROW_W-1:0]       row_in,
  input  logic [ROW_IDX_W-1:0]   row_idx,
  input  logic [FRAME_IDX_W-1:0] frame_idx,
  input  logic [GLYPH_IDX_W-1:0] glyph_idx,
  input  logic                   use_glyph,
  input  logic                   shift_en,
  output logic [ROW_W-1:0]       row_out
);

  logic [ROW_W-1:0] glyph_row;
  logic             feed_bit;

  always_comb begin
    glyph_row = font_row(glyph_idx, row_idx);
    feed_bit  = use_glyph & glyph_row[3'd7 - frame_idx];
    if (shift_en) begin
      row_out = {row_in[ROW_W-2:0], feed_bit};
    end else begin
      row_out = row_in;
    end
  end

endmodule

FILE: hdl/lmts_ctrl.sv
// Sequencer: decodes a command beat and steps row and frame counters per output beat.
// Depends on lmts_pkg for command codes, states and the run control struct.
module lmts_ctrl
  import lmts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_char,
  input  logic      slot_free,
  output logic      in_tready,
  output run_ctrl_t ctrl
);

  state_t                 state_r, state_nxt;
  logic [ROW_IDX_W-1:0]   row_r, row_nxt;
  logic [FRAME_IDX_W-1:0] frame_r, frame_nxt;
  logic [FRAME_IDX_W-1:0] frames_last_r, frames_last_nxt;
  logic                   shift_r, shift_nxt;
  logic                   glyph_r, glyph_nxt;
  logic [GLYPH_IDX_W-1:0] gidx_r, gidx_nxt;
  logic                   accept;
  logic                   is_letter;
  logic [7:0]             char_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      row_r         <= '0;
      frame_r       <= '0;
      frames_last_r <= '0;
      shift_r       <= 1'b0;
      glyph_r       <= 1'b0;
      gidx_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      row_r         <= row_nxt;
      frame_r       <= frame_nxt;
      frames_last_r <= frames_last_nxt;
      shift_r       <= shift_nxt;
      glyph_r       <= glyph_nxt;
      gidx_r        <= gidx_nxt;
    end
  end

  always_comb begin
    in_tready       = (state_r == ST_IDLE);
    accept          = in_tvalid && in_tready;
    is_letter       = (in_char >= CHAR_A) && (in_char <= CHAR_Z);
    char_off        = in_char - CHAR_A;
    state_nxt       = state_r;
    row_nxt         = row_r;
    frame_nxt       = frame_r;
    frames_last_nxt = frames_last_r;
    shift_nxt       = shift_r;
    glyph_nxt       = glyph_r;
    gidx_nxt        = gidx_r;

    ctrl.clear     = 1'b0;
    ctrl.step      = 1'b0;
    ctrl.row_idx   = row_r;
    ctrl.frame_idx = frame_r;
    ctrl.shift_en  = shift_r;
    ctrl.use_glyph = glyph_r;
    ctrl.glyph_idx = gidx_r;
    ctrl.frame_end = (row_r == 3'd7);
    ctrl.last      = (row_r == 3'd7) && (frame_r == frames_last_r);

    unique case (state_r)
      ST_IDLE: begin
        row_nxt   = '0;
        frame_nxt = '0;
        if (accept) begin
          unique case (cmd_t'(in_cmd))
            CMD_START: begin
              ctrl.clear      = 1'b1;
              state_nxt       = ST_RUN;
              frames_last_nxt = START_LAST;
              shift_nxt       = 1'b0;
              glyph_nxt       = 1'b0;
            end
            CMD_CHAR: begin
              if (is_letter) begin
                state_nxt       = ST_RUN;
                frames_last_nxt = GLYPH_LAST;
                shift_nxt       = 1'b1;
                glyph_nxt       = 1'b1;
                gidx_nxt        = char_off[GLYPH_IDX_W-1:0];
              end else if (in_char == CHAR_SPACE) begin
                state_nxt       = ST_RUN;
                frames_last_nxt = SPACE_LAST;
                shift_nxt       = 1'b1;
                glyph_nxt       = 1'b0;
              end
            end
            CMD_FINISH: begin
              state_nxt       = ST_RUN;
              frames_last_nxt = FINISH_LAST;
              shift_nxt       = 1'b1;
              glyph_nxt       = 1'b0;
            end
            CMD_NONE: begin
              state_nxt = ST_IDLE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          ctrl.step = 1'b1;
          row_nxt   = row_r + 3'd1;
          if (row_r == 3'd7) begin
            frame_nxt = frame_r + 3'd1;
            if (frame_r == frames_last_r) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/led_matrix_text_scroller.sv
// Top level of the LED matrix text scroller: frame buffer, output register, sequencer.
// Depends on lmts_pkg, lmts_ctrl and lmts_shift_unit.
//
//  channel  | ports                  | tdata (low bit up)                 | tuser / tlast
//  ---------+------------------------+------------------------------------+------------------
//  input    | in_tvalid/tready       | char_code[7:0]                     | tuser: cmd[1:0]
//  output   | out_tvalid/tready      | row_address[3:0], row_pattern[7:0] | tuser: frame_end
//           |                        |                                    | tlast: last
//
// Start and finish, letters and space emit 8, 7, 7 and 3 frames of 8 row beats.
// One row beat per cycle through the shared row shifter while the output is not stalled.
// Ignored commands emit nothing.
// Output stalls hold the sequencer in place; input is taken only when idle.
// Synchronous active-low reset clears the frame buffer and all control state.
module led_matrix_text_scroller
  import lmts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // row_address[3:0], row_pattern[11:4], zero pad
  output logic        out_tuser,  // frame_end
  output logic        out_tlast   // last
);

  run_ctrl_t        ctrl;
  logic             slot_free;
  logic [ROW_W-1:0] frame_rows_r [ROWS];
  logic [ROW_W-1:0] row_cur;
  logic [ROW_W-1:0] row_new;
  logic             out_valid_r;
  logic [3:0]       out_addr_r;
  logic [ROW_W-1:0] out_pat_r;
  logic             out_fend_r;
  logic             out_last_r;

  assign slot_free = !out_valid_r || out_tready;
  assign row_cur   = frame_rows_r[ctrl.row_idx];

  lmts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_char   (in_tdata),
    .slot_free (slot_free),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  lmts_shift_unit u_shift (
    .row_in    (row_cur),
    .row_idx   (ctrl.row_idx),
    .frame_idx (ctrl.frame_idx),
    .glyph_idx (ctrl.glyph_idx),
    .use_glyph (ctrl.use_glyph),
    .shift_en  (ctrl.shift_en),
    .row_out   (row_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        frame_rows_r[i] <= '0;
      end
    end else if (ctrl.clear) begin
      for (int i = 0; i < ROWS; i++) begin
        frame_rows_r[i] <= '0;
      end
    end else if (ctrl.step) begin
      frame_rows_r[ctrl.row_idx] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      out_addr_r <= {1'b0, ctrl.row_idx} + 4'd1;
      out_pat_r  <= row_new;
      out_fend_r <= ctrl.frame_end;
      out_last_r <= ctrl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_pat_r, out_addr_r};
  assign out_tuser  = out_fend_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/lmts_checker.sv
// Port-level checker for the LED matrix text scroller, bound to the top level.
// Depends only on the top level's ports.
module lmts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] != 4'd0 && out_tdata[3:0] <= 4'd8 && out_tdata[15:12] == 4'd0)
    else $error("row address out of range");

  a_fend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == (out_tdata[3:0] == 4'd8))
    else $error("frame end not on row eight");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last beat not at frame end");

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("ready for input while a run is unfinished");

endmodule

bind led_matrix_text_scroller lmts_checker u_lmts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
